[rtl/esgl_pkg.sv]
// ---------------------------------------------------------------------------
// esgl_pkg: shared types and defaults for the elevation smoother
// sequencer states and parameter defaults
// ---------------------------------------------------------------------------
`default_nettype none

package esgl_pkg;

	localparam int HALF_WINDOW_DEF      = 4;
	localparam int MAX_TRACK_POINTS_DEF = 1048576;

	localparam int ELEV_W  = 24;
	localparam int INDEX_W = 20;
	localparam int TOTAL_W = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT,
		ST_DRAIN_RD,
		ST_DRAIN_SUB
	} esgl_state_t;

endpackage

`default_nettype wire

[rtl/esgl_div.sv]
// ---------------------------------------------------------------------------
// esgl_div: restoring divider
// unsigned quotient, one bit per cycle, done pulses with the quotient ready
// ---------------------------------------------------------------------------
`default_nettype none

module esgl_div #(
	parameter int QW = 28,
	parameter int DW = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [QW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               busy,
	output logic               done,
	output logic [QW-1:0]      quotient
);

	localparam int CW = $clog2(QW + 1);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [DW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[QW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// last quotient bit lands on this edge
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits in DW bits
			rem_q <= fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

[rtl/elevation_smooth_gain_loss.sv]
// ---------------------------------------------------------------------------
// elevation_smooth_gain_loss: centered moving average with gain and loss
// smooths a track of elevation samples over +/- HALF_WINDOW points, clipped
// at both ends, and keeps running gain, loss and extreme values
// ---------------------------------------------------------------------------
//  channel   dir  fields                                             accept
//  s_*       in   tdata: elevation; tlast: last_point                tvalid & tready
//  m_*       out  tdata: smoothed .. lowest; tlast: end_of_track     tvalid & tready
//
// a sample that emits nothing passes through the store read, then write-back
// a sample that emits also runs the bit-serial divider, which dominates,
// one quotient bit per cycle; each further point drained on the last
// sample reruns the divider, after a store read and a subtract when it
// drops a stored sample off the low end of the window
// arst_n clears the sequencer and track control state; the per-item payload and the sample store are not cleared
// a stalled output holds the sequencer in the emit step
// ---------------------------------------------------------------------------
`default_nettype none

module elevation_smooth_gain_loss
	import esgl_pkg::*;
#(
	parameter int HALF_WINDOW      = HALF_WINDOW_DEF,
	parameter int MAX_TRACK_POINTS = MAX_TRACK_POINTS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// [23:0] elevation
	input  wire logic [23:0]  s_tdata,
	input  wire logic         s_tlast,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [23:0] smoothed_elevation, [43:24] point_index, [75:44] total_gain,
	// [107:76] total_loss, [131:108] highest_point, [155:132] lowest_point
	output logic [159:0]      m_tdata,
	output logic              m_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready
);

	localparam int WIN  = 2 * HALF_WINDOW + 1;
	localparam int AW   = $clog2(WIN);
	localparam int DW   = $clog2(WIN + 1);
	localparam int SUMW = ELEV_W + $clog2(WIN);
	localparam int NW   = $clog2(MAX_TRACK_POINTS);

	// sample store, one synchronous read port
	logic signed [ELEV_W-1:0] mem [WIN];
	logic signed [ELEV_W-1:0] rdata_q;

	esgl_state_t state_q, state_d;

	// track state
	logic [NW-1:0]            seen_q;
	logic [NW-1:0]            emitted_q;
	logic [NW-1:0]            n_q;
	logic [NW-1:0]            lo_q;
	logic [AW-1:0]            slot_q;
	logic [AW-1:0]            wa_q;
	logic [AW-1:0]            lo_slot_q;
	logic signed [SUMW-1:0]   sum_q;
	logic signed [ELEV_W-1:0] x_q;
	logic                     last_q;
	logic                     neg_q;
	logic signed [ELEV_W-1:0] prev_q;
	logic [TOTAL_W-1:0]       gain_q;
	logic [TOTAL_W-1:0]       loss_q;
	logic signed [ELEV_W-1:0] high_q;
	logic signed [ELEV_W-1:0] low_q;

	// output register
	logic [159:0] m_tdata_q;
	logic         m_tlast_q;
	logic         m_tvalid_q;

	// control strobes
	logic          accept;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          div_start;
	logic          emit_fire;
	logic          track_done;

	logic [31:0] n32;
	logic [31:0] lo32;
	logic        final_pt;
	logic        need_sub;

	// divider hookup
	logic [SUMW-1:0] mag;
	logic [SUMW-1:0] dividend;
	logic [DW-1:0]   divisor;
	logic            div_busy;
	logic            div_done;
	logic [SUMW-1:0] quotient;

	// emit arithmetic
	logic signed [ELEV_W-1:0] smooth;
	logic signed [ELEV_W:0]   diff;
	logic [ELEV_W:0]          step_up;
	logic [ELEV_W:0]          step_dn;
	logic [TOTAL_W:0]         gain_sum;
	logic [TOTAL_W:0]         loss_sum;
	logic [TOTAL_W-1:0]       gain_nx;
	logic [TOTAL_W-1:0]       loss_nx;
	logic signed [ELEV_W-1:0] high_nx;
	logic signed [ELEV_W-1:0] low_nx;
	logic [NW+INDEX_W-1:0]    index_ext;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
		return (a == AW'(WIN - 1)) ? '0 : a + 1'b1;
	endfunction

	assign n32    = 32'(n_q);
	assign lo32   = 32'(lo_q);
	assign accept = s_tvalid && s_tready;

	// this emission is the last one of the track
	assign final_pt = last_q && (emitted_q == n_q);
	// next drained point drops one sample off the low end of its window
	assign need_sub = (32'(emitted_q) + 32'd1) > (lo32 + 32'(HALF_WINDOW));

	// sequencer: next state and strobes
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = slot_q;
		div_start  = 1'b0;
		emit_fire  = 1'b0;
		track_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					rd_en   = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (n32 >= 32'(HALF_WINDOW) || last_q) begin
					state_d = ST_DIV_GO;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					emit_fire = 1'b1;
					if (final_pt) begin
						track_done = 1'b1;
						state_d    = ST_IDLE;
					end else if (!last_q) begin
						state_d = ST_IDLE;
					end else if (need_sub) begin
						state_d = ST_DRAIN_RD;
					end else begin
						state_d = ST_DIV_GO;
					end
				end
			end
			ST_DRAIN_RD: begin
				rd_en   = 1'b1;
				rd_addr = lo_slot_q;
				state_d = ST_DRAIN_SUB;
			end
			ST_DRAIN_SUB: begin
				state_d = ST_DIV_GO;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sample store
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			mem[wa_q] <= x_q;
		end
	end

	// rounded divide: magnitude plus half the count, sign restored after
	assign mag      = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
	assign divisor  = DW'(n32 - lo32 + 32'd1);
	assign dividend = mag + SUMW'(divisor >> 1);

	esgl_div #(
		.QW(SUMW),
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	// smoothed value and running totals
	assign smooth   = neg_q ? ELEV_W'(-quotient) : ELEV_W'(quotient);
	assign diff     = (ELEV_W + 1)'(smooth) - (ELEV_W + 1)'(prev_q);
	assign step_up  = diff[ELEV_W] ? '0 : diff;
	assign step_dn  = diff[ELEV_W] ? (ELEV_W + 1)'(-diff) : '0;
	assign gain_sum = {1'b0, gain_q} + (TOTAL_W + 1)'(step_up);
	assign loss_sum = {1'b0, loss_q} + (TOTAL_W + 1)'(step_dn);

	always_comb begin
		if (emitted_q == '0) begin
			// first point of the track seeds the extremes
			gain_nx = gain_q;
			loss_nx = loss_q;
			high_nx = smooth;
			low_nx  = smooth;
		end else begin
			gain_nx = gain_sum[TOTAL_W] ? '1 : gain_sum[TOTAL_W-1:0];
			loss_nx = loss_sum[TOTAL_W] ? '1 : loss_sum[TOTAL_W-1:0];
			high_nx = (smooth > high_q) ? smooth : high_q;
			low_nx  = (smooth < low_q) ? smooth : low_q;
		end
	end

	assign index_ext = (NW + INDEX_W)'(emitted_q);

	// track control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			emitted_q <= '0;
			slot_q    <= '0;
			sum_q     <= '0;
			prev_q    <= '0;
			gain_q    <= '0;
			loss_q    <= '0;
			high_q    <= '0;
			low_q     <= '0;
			lo_q      <= '0;
			lo_slot_q <= '0;
		end else begin
			if (accept) begin
				seen_q <= seen_q + 1'b1;
				slot_q <= wrap_inc(slot_q);
			end
			if (state_q == ST_READ) begin
				// drop the sample leaving the window, add the new one
				sum_q <= sum_q + SUMW'(x_q)
					- ((n32 >= 32'(WIN)) ? SUMW'(rdata_q) : SUMW'(0));
				if (n32 >= 32'(2 * HALF_WINDOW)) begin
					lo_q      <= NW'(n32 - 32'(2 * HALF_WINDOW));
					lo_slot_q <= wrap_inc(wa_q);
				end else begin
					lo_q      <= '0;
					lo_slot_q <= '0;
				end
			end
			if (state_q == ST_DRAIN_SUB) begin
				sum_q     <= sum_q - SUMW'(rdata_q);
				lo_q      <= lo_q + 1'b1;
				lo_slot_q <= wrap_inc(lo_slot_q);
			end
			if (track_done) begin
				seen_q    <= '0;
				emitted_q <= '0;
				slot_q    <= '0;
				sum_q     <= '0;
				prev_q    <= '0;
				gain_q    <= '0;
				loss_q    <= '0;
				high_q    <= '0;
				low_q     <= '0;
				lo_q      <= '0;
				lo_slot_q <= '0;
			end else if (emit_fire) begin
				emitted_q <= emitted_q + 1'b1;
				prev_q    <= smooth;
				gain_q    <= gain_nx;
				loss_q    <= loss_nx;
				high_q    <= high_nx;
				low_q     <= low_nx;
			end
		end
	end

	// per-item payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= s_tdata;
			n_q    <= seen_q;
			wa_q   <= slot_q;
			// an overlong track ends at the last index that fits
			last_q <= s_tlast || (seen_q == NW'(MAX_TRACK_POINTS - 1));
		end
		if (div_start) begin
			neg_q <= sum_q[SUMW-1];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_tdata_q <= {4'b0, low_nx, high_nx, loss_nx, gain_nx,
				index_ext[INDEX_W-1:0], smooth};
			m_tlast_q <= final_pt;
		end
	end

	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tvalid = m_tvalid_q;

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy)
		else $error("input ready while divider busy");
	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		emitted_q <= seen_q)
		else $error("more points emitted than seen");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> divisor != '0)
		else $error("window count is zero");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		track_done |=> seen_q == '0 && emitted_q == '0)
		else $error("track state not cleared after end");
`endif

endmodule

`default_nettype wire
